// ===== rtl/core/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared item types and constants for the exhaustive tour search block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

    // Action codes carried by an input item
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_SOLVE = 1'b1;

    // Output cost field saturates here
    localparam int          COST_OUT_W   = 19;
    localparam logic [18:0] COST_OUT_MAX = 19'h7FFFF;

    // One input item: an adjacency write or a solve request
    typedef struct packed {
        logic        action;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [15:0] weight;
        logic        no_edge;
    } t_in_item;

    // One result item: one vertex of the best tour
    typedef struct packed {
        logic [2:0]  vertex;
        logic [18:0] total_cost;
        logic        found;
        logic        last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/tsp_adj_mem.sv =====
// ----------------------------------------------------------------------------
// tsp_adj_mem
// Adjacency store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_adj_mem #(
    parameter int DEPTH = 36,
    parameter int WIDTH = 17,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data valid in the cycle after the address
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/tsp_cost_unit.sv =====
// ----------------------------------------------------------------------------
// tsp_cost_unit
// Shared cost adder and best-cost compare used by the evaluate and close steps.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_cost_unit #(
    parameter int WB  = 16,
    parameter int CST = 19
) (
    input  wire logic [CST-1:0] i_base,
    input  wire logic [WB-1:0]  i_weight,
    input  wire logic [CST-1:0] i_best,
    output logic      [CST-1:0] o_sum,
    output logic                o_less
);

    // partial cost plus edge weight
    assign o_sum  = i_base + CST'(i_weight);

    // strictly cheaper than the best tour so far
    assign o_less = (o_sum < i_best);

endmodule

`default_nettype wire

// ===== rtl/core/tsp_exhaustive_tour_search.sv =====
// ----------------------------------------------------------------------------
// tsp_exhaustive_tour_search
// Exact shortest-tour search over a small directed graph, iterative DFS.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on i_item when start is high and busy is low.
//   A load item (action = load) writes one adjacency entry and
//   gives no result; rows or columns at or above NODES are dropped.
//   A solve item raises busy and runs a depth-first search from vertex 0
//   over all tours, driven by a small sequencer around one adder/compare
//   unit and a single-port-read adjacency memory.
//   Search steps: a candidate vertex that is already visited is skipped in
//   the issue state; any other is read from memory, then evaluated. A full
//   path reads its closing edge, then compares its cost, and the end of each
//   candidate scan or a closing edge leads to a backtrack.
//   Results then leave on o_result, one per cycle with o_strobe high:
//   NODES+1 vertices of the best tour, or a single item with found = 0.
//   The receiver cannot stall; busy drops after the last result.
//   Reset is synchronous on i_rst_n and returns the block to idle. The
//   adjacency memory is not cleared: every edge must be loaded before a
//   solve reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_exhaustive_tour_search #(
    parameter int NODES       = 6,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire tsp_pkg::t_in_item  i_item,
    output logic                    o_strobe,
    output tsp_pkg::t_out_item      o_result
);

    localparam int VW    = $clog2(NODES);
    localparam int CW    = $clog2(NODES + 1);
    localparam int DEPTH = NODES * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = WEIGHT_BITS + 1;
    localparam int CST   = WEIGHT_BITS + 3;
    localparam int COST_W_PAD = tsp_pkg::COST_OUT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ISSUE = 6'b000010,
        S_EVAL  = 6'b000100,
        S_CLOSE = 6'b001000,
        S_POP   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // search state
    logic [CW-1:0]    r_depth;
    logic [NODES-1:0] r_visited;
    logic             r_found;
    logic [CW-1:0]    r_oidx;
    logic [VW-1:0]    r_cur;
    logic [CST-1:0]   r_cost;
    logic [CW-1:0]    r_cand;
    logic [CST-1:0]   r_best;
    logic [VW-1:0]    r_path     [NODES];
    logic [CST-1:0]   r_cost_stk [NODES];
    logic [CW-1:0]    r_cand_stk [NODES];
    logic [VW-1:0]    r_tour     [NODES];

    logic             accept;
    logic             do_solve;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [EW-1:0]    mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [EW-1:0]    mem_rdata;
    logic [VW-1:0]    rd_col;
    logic [31:0]      wt_ext;
    logic             edge_ok;
    logic             at_leaf;
    logic             cand_end;
    logic             cand_seen;
    logic             top_level;
    logic [CST-1:0]   sum;
    logic             less;
    logic             better;
    logic [VW-1:0]    push_idx;
    logic [VW-1:0]    pop_idx;
    logic             out_last;
    logic [CST+COST_W_PAD-1:0] best_ext;

    // handshake
    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign do_solve = accept && (i_item.action == tsp_pkg::ACT_SOLVE);

    // load path: out-of-range vertices are dropped
    assign wt_ext    = 32'(i_item.weight);
    assign mem_we    = accept && (i_item.action == tsp_pkg::ACT_LOAD)
                       && ({1'b0, i_item.row} < 4'(NODES))
                       && ({1'b0, i_item.col} < 4'(NODES));
    assign mem_waddr = AW'(int'(i_item.row) * NODES + int'(i_item.col));
    assign mem_wdata = i_item.no_edge ? {1'b1, {WEIGHT_BITS{1'b0}}}
                                      : {1'b0, wt_ext[WEIGHT_BITS-1:0]};

    // search read address: closing edge at full depth, else the candidate
    assign at_leaf   = (r_depth == CW'(NODES));
    assign cand_end  = (r_cand == CW'(NODES));
    assign cand_seen = r_visited[r_cand[VW-1:0]];
    assign rd_col    = at_leaf ? '0 : r_cand[VW-1:0];
    assign mem_raddr = AW'(int'(r_cur) * NODES + int'(rd_col));

    tsp_adj_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW),
        .AW    (AW)
    ) u_adj_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign edge_ok = !mem_rdata[WEIGHT_BITS];

    tsp_cost_unit #(
        .WB  (WEIGHT_BITS),
        .CST (CST)
    ) u_cost_unit (
        .i_base   (r_cost),
        .i_weight (mem_rdata[WEIGHT_BITS-1:0]),
        .i_best   (r_best),
        .o_sum    (sum),
        .o_less   (less)
    );

    assign better    = edge_ok && (!r_found || less);
    assign top_level = (r_depth == CW'(1));
    assign push_idx  = r_depth[VW-1:0];
    assign pop_idx   = VW'(r_depth - CW'(2));

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (do_solve) n_state = S_ISSUE;
            end
            S_ISSUE: begin
                if (at_leaf)        n_state = S_CLOSE;
                else if (cand_end)  n_state = S_POP;
                else if (cand_seen) n_state = S_ISSUE;
                else                n_state = S_EVAL;
            end
            S_EVAL:  n_state = S_ISSUE;
            S_CLOSE: n_state = S_POP;
            S_POP: begin
                n_state = top_level ? S_OUT : S_ISSUE;
            end
            S_OUT: begin
                if (out_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_depth   <= '0;
            r_visited <= '0;
            r_found   <= 1'b0;
            r_oidx    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (do_solve) begin
                        r_depth   <= CW'(1);
                        r_visited <= NODES'(1);
                        r_found   <= 1'b0;
                    end
                end
                S_EVAL: begin
                    if (edge_ok) begin
                        r_depth                    <= r_depth + CW'(1);
                        r_visited[r_cand[VW-1:0]]  <= 1'b1;
                    end
                end
                S_CLOSE: begin
                    if (better) r_found <= 1'b1;
                end
                S_POP: begin
                    if (top_level) begin
                        r_depth   <= '0;
                        r_visited <= '0;
                        r_oidx    <= '0;
                    end else begin
                        r_depth          <= r_depth - CW'(1);
                        r_visited[r_cur] <= 1'b0;
                    end
                end
                S_OUT: begin
                    r_oidx <= r_oidx + CW'(1);
                end
                default: ;
            endcase
        end
    end

    // search datapath and stacks
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (do_solve) begin
                    r_cur     <= '0;
                    r_cost    <= '0;
                    r_cand    <= '0;
                    r_best    <= '1;
                    r_path[0] <= '0;
                end
            end
            S_ISSUE: begin
                if (!at_leaf && !cand_end && cand_seen) r_cand <= r_cand + CW'(1);
            end
            S_EVAL: begin
                if (edge_ok) begin
                    r_cost_stk[VW'(r_depth - CW'(1))] <= r_cost;
                    r_cand_stk[VW'(r_depth - CW'(1))] <= r_cand + CW'(1);
                    r_path[push_idx]                  <= r_cand[VW-1:0];
                    r_cur                             <= r_cand[VW-1:0];
                    r_cost                            <= sum;
                    r_cand                            <= '0;
                end else begin
                    r_cand <= r_cand + CW'(1);
                end
            end
            S_CLOSE: begin
                if (better) begin
                    r_best <= sum;
                    for (int k = 0; k < NODES; k++) begin
                        r_tour[k] <= r_path[k];
                    end
                end
            end
            S_POP: begin
                if (!top_level) begin
                    r_cur  <= r_path[pop_idx];
                    r_cost <= r_cost_stk[pop_idx];
                    r_cand <= r_cand_stk[pop_idx];
                end
            end
            default: ;
        endcase
    end

    // result items, the last one returns to vertex 0
    assign best_ext = {{COST_W_PAD{1'b0}}, r_best};
    assign out_last = !r_found || (r_oidx == CW'(NODES));
    assign o_strobe = (r_state == S_OUT);

    always_comb begin
        o_result = '0;
        o_result.found = r_found;
        o_result.last  = out_last;
        if (r_found) begin
            o_result.vertex = (r_oidx == CW'(NODES)) ? 3'd0
                                                     : 3'(r_tour[r_oidx[VW-1:0]]);
            if (best_ext > (CST + COST_W_PAD)'(tsp_pkg::COST_OUT_MAX)) begin
                o_result.total_cost = tsp_pkg::COST_OUT_MAX;
            end else begin
                o_result.total_cost = best_ext[tsp_pkg::COST_OUT_W-1:0];
            end
        end
    end

`ifndef SYNTH
    // a result only appears while the solve holds the block
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    // one visited bit per vertex on the current path
    a_visited_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE || r_state == S_EVAL || r_state == S_CLOSE ||
         r_state == S_POP) |-> ($countones(r_visited) == int'(r_depth)))
        else $error("visited mask out of step with search depth");

    // busy only ends right after the final result
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_strobe && o_result.last))
        else $error("solve ended without a final result");

    // a closing edge is only checked on a full path
    a_close_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLOSE) |-> (r_depth == CW'(NODES)))
        else $error("tour closed before all vertices were visited");

    // the no-tour answer is a single item
    a_notour_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.found) |-> o_result.last)
        else $error("no-tour result not marked last");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the exhaustive tour search block against its own tour predictor.
// A full adjacency load opens the run. A directed table then covers the
// empty graph, a single forced cycle, ignored out-of-range writes, edge
// removal, equal-cost tours and zero weights. Random graph rewrites follow,
// each ending in a solve, with random start gaps and drain pauses. Every
// result item is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------

module testbench;

    localparam int NODES       = 6;
    localparam int WEIGHT_BITS = 16;
    localparam int ITEM_TARGET = 310;
    localparam int SETTLE_CYC  = 100;
    localparam int MAX_REPORTS = 10;

    localparam logic [15:0] WMASK =
        (WEIGHT_BITS >= 16) ? 16'hFFFF : 16'((1 << WEIGHT_BITS) - 1);

    // How a stimulus row is checked
    typedef enum logic {
        CHECK_PREDICT,
        CHECK_TYPED
    } t_check;

    // Visiting order of a closed tour, vertex 0 first
    typedef logic [0:NODES][2:0] t_tour;

    // One row of stimulus, with its result typed in where it is obvious
    typedef struct packed {
        tsp_pkg::t_in_item item;
        t_check            check;
        logic              exp_found;
        logic [18:0]       exp_cost;
        t_tour             exp_tour;
    } t_step;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    tsp_pkg::t_in_item  i_item  = '0;
    logic               o_strobe;
    tsp_pkg::t_out_item o_result;

    // Predictor state: current adjacency contents
    bit          graph_on [NODES][NODES];
    logic [15:0] graph_w  [NODES][NODES];

    tsp_pkg::t_out_item tour_expect[$];
    t_step              directed_steps[$];
    int                 fail_count   = 0;
    int                 useful_count = 0;

    tsp_exhaustive_tour_search #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #100_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus row builders
    // ------------------------------------------------------------------
    function automatic t_step row_load(int r, int c, logic [15:0] w, logic absent);
        t_step s;
        s              = '0;
        s.item.action  = tsp_pkg::ACT_LOAD;
        s.item.row     = 3'(r);
        s.item.col     = 3'(c);
        s.item.weight  = w;
        s.item.no_edge = absent;
        s.check        = CHECK_PREDICT;
        return s;
    endfunction

    function automatic t_step row_solve();
        t_step s;
        s             = '0;
        s.item.action = tsp_pkg::ACT_SOLVE;
        s.check       = CHECK_PREDICT;
        return s;
    endfunction

    function automatic t_step row_solve_expect(logic found, logic [18:0] cost, t_tour tour);
        t_step s;
        s           = row_solve();
        s.check     = CHECK_TYPED;
        s.exp_found = found;
        s.exp_cost  = cost;
        s.exp_tour  = tour;
        return s;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_step s);
        directed_steps.insert(directed_steps.size(), s);
    endfunction

    // Append one expected result item
    function automatic void expect_item(tsp_pkg::t_out_item r);
        tour_expect.insert(tour_expect.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // Expected result items for one solve
    // ------------------------------------------------------------------
    function automatic void queue_tour_items(logic found, logic [18:0] cost, t_tour tour);
        tsp_pkg::t_out_item r;
        r = '0;
        if (!found) begin
            r.last = 1'b1;
            expect_item(r);
        end else begin
            for (int k = 0; k <= NODES; k++) begin
                r.vertex     = tour[k];
                r.total_cost = cost;
                r.found      = 1'b1;
                r.last       = (k == NODES);
                expect_item(r);
            end
        end
    endfunction

    // Cheapest closed tour from vertex 0. Permutations of vertices 1..N-1
    // are walked in lexicographic order, which is the depth-first order of
    // the search, so a strict compare keeps the first of equal-cost tours.
    function automatic void predict_best_tour();
        int    perm [NODES];
        int    i, j, tmp, prev, cost, best;
        bit    ok, have, more;
        t_tour best_tour;
        for (i = 0; i < NODES; i++) perm[i] = i;
        have      = 1'b0;
        best      = 0;
        best_tour = '0;
        more      = 1'b1;
        while (more) begin
            ok   = 1'b1;
            cost = 0;
            prev = 0;
            for (i = 1; i <= NODES; i++) begin
                j = (i == NODES) ? 0 : perm[i];
                if (!graph_on[prev][j]) ok = 1'b0;
                cost += int'(graph_w[prev][j]);
                prev = j;
            end
            if (ok && (!have || cost < best)) begin
                have = 1'b1;
                best = cost;
                for (i = 0; i < NODES; i++) best_tour[i] = 3'(perm[i]);
                best_tour[NODES] = 3'd0;
            end
            // next permutation of perm[1..NODES-1]
            i = NODES - 2;
            while (i >= 1 && perm[i] >= perm[i+1]) i--;
            if (i < 1) begin
                more = 1'b0;
            end else begin
                j = NODES - 1;
                while (perm[j] <= perm[i]) j--;
                tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
                i++;
                j = NODES - 1;
                while (i < j) begin
                    tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
                    i++;
                    j--;
                end
            end
        end
        queue_tour_items(have, (best > int'(tsp_pkg::COST_OUT_MAX)) ?
                         tsp_pkg::COST_OUT_MAX : 19'(best), best_tour);
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Drive one item, update the predictor on acceptance, then idle
    // ------------------------------------------------------------------
    task automatic run_step(t_step s, bit calm);
        int gap;
        start  <= 1'b1;
        i_item <= s.item;
        do @(posedge i_clk); while (busy !== 1'b0);

        if (s.item.action == tsp_pkg::ACT_LOAD) begin
            if (s.item.row < NODES && s.item.col < NODES) begin
                graph_on[s.item.row][s.item.col] = !s.item.no_edge;
                graph_w[s.item.row][s.item.col]  = s.item.no_edge ? 16'd0 :
                                                   (s.item.weight & WMASK);
                useful_count++;
            end
        end else begin
            if (s.check == CHECK_TYPED)
                queue_tour_items(s.exp_found, s.exp_cost, s.exp_tour);
            else
                predict_best_tour();
            useful_count++;
        end

        gap = pick_gap(calm);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every expected result has come
    task automatic wait_drained();
        if (tour_expect.size() != 0) begin
            start <= 1'b0;
            while (tour_expect.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic note_failure(string what, tsp_pkg::t_out_item want,
                                tsp_pkg::t_out_item got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s: expected v=%0d cost=%0d found=%0b last=%0b, ",
                     $realtime, what, want.vertex, want.total_cost, want.found,
                     want.last,
                     "got v=%0d cost=%0d found=%0b last=%0b",
                     got.vertex, got.total_cost, got.found, got.last);
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        tsp_pkg::t_out_item want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (tour_expect.size() == 0) begin
                note_failure("result with none expected", '0, o_result);
            end else begin
                want = tour_expect.pop_front();
                if (o_strobe !== 1'b1 ||
                    o_result.vertex !== want.vertex ||
                    o_result.total_cost !== want.total_cost ||
                    o_result.found !== want.found ||
                    o_result.last !== want.last)
                    note_failure("result mismatch", want, o_result);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_step s;
        int    n_loads;
        int    absent_pct;
        int    r;
        bit    calm;
        bit    ties;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every entry written before any solve reads it; start all absent
        for (int rw = 0; rw < NODES; rw++)
            for (int cl = 0; cl < NODES; cl++)
                run_step(row_load(rw, cl, 16'hFFFF, 1'b1), 1'b1);

        // directed rows
        add_row(row_solve_expect(1'b0, 19'd0, '0));  // empty graph
        add_row(row_load(0, 1, 16'hFFFF, 1'b0));
        add_row(row_load(1, 2, 16'hFFFF, 1'b0));
        add_row(row_load(2, 3, 16'hFFFF, 1'b0));
        add_row(row_load(3, 4, 16'hFFFF, 1'b0));
        add_row(row_load(4, 5, 16'hFFFF, 1'b0));
        add_row(row_load(5, 0, 16'hFFFF, 1'b0));
        // the only tour, all weights at maximum
        add_row(row_solve_expect(1'b1, 19'd393210,
            {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0}));
        // out-of-range writes are dropped
        add_row(row_load(7, 0, 16'h0000, 1'b0));
        add_row(row_load(0, 6, 16'h0000, 1'b0));
        add_row(row_load(6, 7, 16'h5A5A, 1'b0));
        // removing the closing edge leaves no tour
        add_row(row_load(5, 0, 16'hFFFF, 1'b1));
        add_row(row_solve_expect(1'b0, 19'd0, '0));
        // second tour of equal cost: the first one found stays
        add_row(row_load(5, 0, 16'h0000, 1'b0));
        add_row(row_load(2, 4, 16'hFFFF, 1'b0));
        add_row(row_load(4, 3, 16'hFFFF, 1'b0));
        add_row(row_load(3, 5, 16'hFFFF, 1'b0));
        add_row(row_solve());
        // now the later tour is strictly cheaper
        add_row(row_load(3, 5, 16'hFFFE, 1'b0));
        add_row(row_solve());
        add_row(row_load(0, 1, 16'h0000, 1'b0));
        add_row(row_solve());

        foreach (directed_steps[k])
            run_step(directed_steps[k], 1'b0);
        wait_drained();

        // random graph rewrites, each closed by a solve
        while (useful_count < ITEM_TARGET) begin
            calm       = ($urandom_range(0, 4) == 0);
            absent_pct = ($urandom_range(0, 9) == 0) ? 75 : 20;
            ties       = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: n_loads = $urandom_range(0, 3);
                1: n_loads = $urandom_range(4, 10);
                default: n_loads = $urandom_range(11, 24);
            endcase

            for (int k = 0; k < n_loads; k++) begin
                s              = row_solve();
                s.item.action  = tsp_pkg::ACT_LOAD;
                s.item.row     = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
                                                               3'($urandom_range(0, NODES - 1));
                s.item.col     = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
                                                               3'($urandom_range(0, NODES - 1));
                s.item.no_edge = ($urandom_range(0, 99) < absent_pct);
                r = $urandom_range(0, 9);
                if (ties)
                    s.item.weight = 16'($urandom_range(0, 2));
                else if (r == 0)
                    s.item.weight = 16'h0000;
                else if (r == 1)
                    s.item.weight = 16'hFFFF;
                else
                    s.item.weight = 16'($urandom_range(0, 65535));
                run_step(s, calm);
            end

            if ($urandom_range(0, 7) == 0) wait_drained();

            // unused fields of a solve carry noise
            s             = row_solve();
            s.item        = tsp_pkg::t_in_item'(24'($urandom));
            s.item.action = tsp_pkg::ACT_SOLVE;
            run_step(s, calm);
        end

        start <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (fail_count == 0 && tour_expect.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
